// ----- hw/rtl/ptcc_pkg.sv -----
package ptcc_pkg;

  // tree depth is capped no matter how much storage is built
  localparam int HEIGHT_CAP = 8;
  localparam int LVL_W      = 3;
  localparam int HGT_W      = 4;
  localparam int COUNT_W    = 48;
  localparam int CAP_W      = 37;
  localparam int DIFF_W     = 8;
  localparam int CMD_DEPTH  = 2;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_TREE_HEIGHT     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_CAPACITY = 1'b1;

  // command kinds handed from front to back
  typedef enum logic [1:0] {
    CMD_FIRST,
    CMD_EMPTY,
    CMD_STEP,
    CMD_END
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [LVL_W-1:0]   lvl;
    logic [HGT_W-1:0]   height;
  } cmd_t;

  // queue fill status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// ----- hw/rtl/ptcc_cmd_fifo.sv -----
module ptcc_cmd_fifo
  import ptcc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  cmd_t       push_cmd,
  input  logic       pop,
  output cmd_t       head_cmd,
  output fifo_stat_t stat
);

  localparam int PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMD_DEPTH + 1);

  cmd_t             mem_r [CMD_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push;
  logic             do_pop;

  assign stat.full  = (cnt_r == CNT_W'(CMD_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_cmd   = mem_r[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/ptcc_front.sv -----
module ptcc_front
  import ptcc_pkg::*;
#(
  parameter int MAX_LEVELS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [HGT_W-1:0]  tree_height,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              in_tlast,
  input  logic [DIFF_W-1:0] in_tdata,
  input  fifo_stat_t        stat,
  output logic              push,
  output cmd_t              push_cmd
);

  localparam int NUM_LVL = (MAX_LEVELS < HEIGHT_CAP) ? MAX_LEVELS : HEIGHT_CAP;

  localparam logic [1:0] PH_FIRST = 2'd0;
  localparam logic [1:0] PH_RUN   = 2'd1;
  localparam logic [1:0] PH_DONE  = 2'd2;

  logic [1:0]       phase_r;
  logic [1:0]       phase_nxt;
  logic [HGT_W-1:0] run_height_r;
  logic [HGT_W-1:0] run_height_nxt;
  logic [HGT_W-1:0] eff_height;
  logic [HGT_W-1:0] top_lvl;
  logic             xfer;

  // once the stream has ended, items are taken and dropped
  assign in_tready = (phase_r == PH_DONE) || !stat.full;
  assign xfer      = in_tvalid && in_tready;

  // clamp the configured height into the supported range
  always_comb begin
    eff_height = tree_height;
    if (eff_height == '0) begin
      eff_height = HGT_W'(1);
    end
    if (eff_height > HGT_W'(NUM_LVL)) begin
      eff_height = HGT_W'(NUM_LVL);
    end
  end

  assign top_lvl = run_height_r - 1'b1;

  // classify each transfer into a command
  always_comb begin
    phase_nxt       = phase_r;
    run_height_nxt  = run_height_r;
    push            = 1'b0;
    push_cmd.kind   = CMD_STEP;
    push_cmd.height = run_height_r;
    push_cmd.lvl    = (in_tdata < DIFF_W'(top_lvl)) ? LVL_W'(in_tdata) : LVL_W'(top_lvl);
    if (xfer) begin
      unique case (phase_r)
        PH_FIRST: begin
          push = 1'b1;
          if (in_tlast) begin
            push_cmd.kind = CMD_EMPTY;
            phase_nxt     = PH_DONE;
          end else begin
            push_cmd.kind   = CMD_FIRST;
            push_cmd.height = eff_height;
            run_height_nxt  = eff_height;
            phase_nxt       = PH_RUN;
          end
        end
        PH_RUN: begin
          push = 1'b1;
          if (in_tlast) begin
            push_cmd.kind = CMD_END;
            phase_nxt     = PH_DONE;
          end
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_FIRST;
      run_height_r <= HGT_W'(1);
    end else begin
      phase_r      <= phase_nxt;
      run_height_r <= run_height_nxt;
    end
  end

endmodule

// ----- hw/rtl/ptcc_back.sv -----
module ptcc_back
  import ptcc_pkg::*;
#(
  parameter int MAX_LEVELS   = 8,
  parameter int ADDRESS_BITS = 36
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [CAP_W-1:0]        output_capacity,
  input  cmd_t                    head_cmd,
  input  fifo_stat_t              stat,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [ADDRESS_BITS-1:0] out_addr,
  output logic [COUNT_W-1:0]      out_count,
  output logic                    out_last,
  output logic                    out_err
);

  localparam int NUM_LVL = (MAX_LEVELS < HEIGHT_CAP) ? MAX_LEVELS : HEIGHT_CAP;
  localparam int IDX_W   = (NUM_LVL > 1) ? $clog2(NUM_LVL) : 1;
  localparam int NFA_W   = ADDRESS_BITS + 1;
  localparam int CW      = (NFA_W > CAP_W) ? NFA_W : CAP_W;
  localparam int SUM_W   = CW + 1;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CLOSE  = 3'd1;
  localparam logic [2:0] ST_FINISH = 3'd2;
  localparam logic [2:0] ST_SINGLE = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  logic [COUNT_W-1:0]      open_count_r [NUM_LVL];
  logic [ADDRESS_BITS-1:0] open_addr_r  [NUM_LVL];

  logic [2:0]        state_r,  state_nxt;
  logic [LVL_W-1:0]  idx_r,    idx_nxt;
  logic [LVL_W-1:0]  lvl_r,    lvl_nxt;
  logic [HGT_W-1:0]  lo_r,     lo_nxt;
  logic [HGT_W-1:0]  height_r, height_nxt;
  logic [HGT_W-1:0]  need_r,   need_nxt;
  logic              fit_r,    fit_nxt;
  logic              end_r,    end_nxt;
  logic              inc_r,    inc_nxt;
  logic              err_r,    err_nxt;
  logic [NFA_W-1:0]  nfa_r,    nfa_nxt;

  logic                    out_valid_r;
  logic [ADDRESS_BITS-1:0] out_addr_r;
  logic [COUNT_W-1:0]      out_count_r;
  logic                    out_last_r;
  logic                    out_err_r;

  logic                    emit_ok;
  logic                    emit;
  logic [ADDRESS_BITS-1:0] emit_addr;
  logic [COUNT_W-1:0]      emit_count;
  logic                    emit_last;
  logic                    emit_err;
  logic                    do_finish;

  logic [HGT_W-1:0] head_lo;
  logic [HGT_W-1:0] head_need;
  logic [CW-1:0]    cap_lim;
  logic [CW-1:0]    eff_cap;
  logic [SUM_W-1:0] need_sum;
  logic             head_fit;
  logic             at_lo;

  // capacity check for the counters this command will open
  assign head_lo   = (head_cmd.kind == CMD_STEP) ? HGT_W'(head_cmd.lvl) + 1'b1 : '0;
  assign head_need = head_cmd.height - head_lo;
  assign cap_lim   = CW'(1) << ADDRESS_BITS;
  assign eff_cap   = (CW'(output_capacity) < cap_lim) ? CW'(output_capacity) : cap_lim;
  assign need_sum  = SUM_W'(nfa_r) + SUM_W'(head_need);
  assign head_fit  = (need_sum <= SUM_W'(eff_cap));

  assign emit_ok = !out_valid_r || out_ready;
  assign at_lo   = ({1'b0, idx_r} == lo_r);

  // command sequencer
  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    lvl_nxt    = lvl_r;
    lo_nxt     = lo_r;
    height_nxt = height_r;
    need_nxt   = need_r;
    fit_nxt    = fit_r;
    end_nxt    = end_r;
    inc_nxt    = inc_r;
    err_nxt    = err_r;
    nfa_nxt    = nfa_r;
    pop        = 1'b0;
    emit       = 1'b0;
    emit_addr  = open_addr_r[idx_r[IDX_W-1:0]];
    emit_count = open_count_r[idx_r[IDX_W-1:0]];
    emit_last  = 1'b0;
    emit_err   = 1'b0;
    do_finish  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!stat.empty) begin
          pop        = 1'b1;
          lvl_nxt    = head_cmd.lvl;
          lo_nxt     = head_lo;
          height_nxt = head_cmd.height;
          need_nxt   = head_need;
          fit_nxt    = head_fit;
          end_nxt    = (head_cmd.kind == CMD_END);
          idx_nxt    = LVL_W'(head_cmd.height - 1'b1);
          unique case (head_cmd.kind)
            CMD_FIRST: begin
              inc_nxt   = 1'b0;
              err_nxt   = 1'b1;
              state_nxt = head_fit ? ST_FINISH : ST_SINGLE;
            end
            CMD_EMPTY: begin
              err_nxt   = 1'b0;
              state_nxt = ST_SINGLE;
            end
            CMD_STEP: begin
              inc_nxt = 1'b1;
              err_nxt = 1'b1;
              if (head_lo < head_cmd.height) begin
                state_nxt = ST_CLOSE;
              end else begin
                idx_nxt   = head_cmd.lvl;
                state_nxt = ST_FINISH;
              end
            end
            CMD_END: begin
              state_nxt = ST_CLOSE;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      // one finished counter per transfer, deepest first
      ST_CLOSE: begin
        if (emit_ok) begin
          emit      = 1'b1;
          emit_last = at_lo && (end_r || fit_r);
          if (at_lo) begin
            if (end_r) begin
              state_nxt = ST_DONE;
            end else begin
              idx_nxt   = lvl_r;
              state_nxt = ST_FINISH;
            end
          end else begin
            idx_nxt = idx_r - 1'b1;
          end
        end
      end
      // bump the counter at the level on a step and open the deeper ones, or go to the error result
      ST_FINISH: begin
        do_finish = fit_r;
        if (fit_r) begin
          nfa_nxt   = nfa_r + NFA_W'(need_r);
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_SINGLE;
        end
      end
      // empty stream or capacity error
      ST_SINGLE: begin
        emit_addr  = '0;
        emit_count = '0;
        if (emit_ok) begin
          emit      = 1'b1;
          emit_last = 1'b1;
          emit_err  = err_r;
          state_nxt = ST_DONE;
        end
      end
      // keep the queue drained after the stream has stopped
      ST_DONE: begin
        pop = !stat.empty;
      end
      default: begin
        state_nxt = ST_DONE;
      end
    endcase
  end

  // per-level counter lanes
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_LVL; i++) begin
      if (do_finish) begin
        if ((HGT_W'(i) >= lo_r) && (HGT_W'(i) < height_r)) begin
          open_count_r[i] <= COUNT_W'(1);
          open_addr_r[i]  <= ADDRESS_BITS'(nfa_r + NFA_W'(HGT_W'(i) - lo_r));
        end else if (inc_r && (LVL_W'(i) == idx_r) && !(&open_count_r[i])) begin
          open_count_r[i] <= open_count_r[i] + 1'b1;
        end
      end
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      nfa_r   <= '0;
    end else begin
      state_r <= state_nxt;
      nfa_r   <= nfa_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    lvl_r    <= lvl_nxt;
    lo_r     <= lo_nxt;
    height_r <= height_nxt;
    need_r   <= need_nxt;
    fit_r    <= fit_nxt;
    end_r    <= end_nxt;
    inc_r    <= inc_nxt;
    err_r    <= err_nxt;
  end

  // result output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_addr_r  <= emit_addr;
      out_count_r <= emit_count;
      out_last_r  <= emit_last;
      out_err_r   <= emit_err;
    end
  end

  assign out_valid = out_valid_r;
  assign out_addr  = out_addr_r;
  assign out_count = out_count_r;
  assign out_last  = out_last_r;
  assign out_err   = out_err_r;

endmodule

// ----- hw/rtl/prefix_tree_child_counter_core.sv -----
// Builds the preorder child-count table of a prefix tree from a sorted tuple stream given
// as diff levels (in_tdata) with in_tlast marking the end of the stream. Each finished
// counter comes out as one transfer of (address, count); out_tlast marks the last transfer
// caused by an input, out_tuser flags a capacity overflow, after which the block stops
// until reset. Configure tree_height (index 0) and output_capacity (index 1) before the
// first item. The front side takes one item per cycle, while the queue is not full, into a
// two-entry command queue; the back sequencer fetches a command, closes counters deepest
// first, one per output transfer, and then updates and opens counters; on a capacity
// error it gives the error result after any closes, and the end marker only closes
// counters. Closes move one per cycle through the single output register;
// a stalled result holds the sequencer and, once the queue is full, the input side.
module prefix_tree_child_counter_core
  import ptcc_pkg::*;
#(
  parameter int MAX_LEVELS   = 8,
  parameter int ADDRESS_BITS = 36
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [CAP_W-1:0]     cfg_wdata,
  // input stream
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic                 in_tlast,  // is_end
  input  logic [DIFF_W-1:0]    in_tdata,  // diff_level
  // result stream
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [((ADDRESS_BITS + COUNT_W + 7) / 8) * 8 - 1:0]
                               out_tdata, // write_address, count_value, zero fill
  output logic                 out_tlast, // last_of_run
  output logic                 out_tuser  // overflow_error
);

  localparam int OUT_W = ((ADDRESS_BITS + COUNT_W + 7) / 8) * 8;

  logic [HGT_W-1:0]        tree_height_r;
  logic [CAP_W-1:0]        capacity_r;
  logic                    push;
  cmd_t                    push_cmd;
  cmd_t                    head_cmd;
  logic                    pop;
  fifo_stat_t              stat;
  logic [ADDRESS_BITS-1:0] res_addr;
  logic [COUNT_W-1:0]      res_count;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tree_height_r <= HGT_W'(1);
      capacity_r    <= CAP_W'(1) << 36;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_TREE_HEIGHT:     tree_height_r <= cfg_wdata[HGT_W-1:0];
        CFG_OUTPUT_CAPACITY: capacity_r    <= cfg_wdata;
        default:             capacity_r    <= capacity_r;
      endcase
    end
  end

  ptcc_front #(
    .MAX_LEVELS (MAX_LEVELS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .tree_height (tree_height_r),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tlast    (in_tlast),
    .in_tdata    (in_tdata),
    .stat        (stat),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  ptcc_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .stat     (stat)
  );

  ptcc_back #(
    .MAX_LEVELS   (MAX_LEVELS),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .output_capacity (capacity_r),
    .head_cmd        (head_cmd),
    .stat            (stat),
    .pop             (pop),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_addr        (res_addr),
    .out_count       (res_count),
    .out_last        (out_tlast),
    .out_err         (out_tuser)
  );

  // pack result fields, address in the low bits
  assign out_tdata = OUT_W'({res_count, res_addr});

endmodule
